### rtl/plsu_pkg.sv
package plsu_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = 5;
    localparam int POS_W  = 8;
    localparam int VAL_W  = 32;
    localparam int REQ_W  = 4;
    localparam int STAT_W = 3;
    localparam int IN_W   = POS_W + VAL_W;
    localparam int OUT_W  = STAT_W + CNT_W + VAL_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_FRONT = 4'd0,
        REQ_INS_BACK  = 4'd1,
        REQ_INS_MID   = 4'd2,
        REQ_DEL_FRONT = 4'd3,
        REQ_DEL_BACK  = 4'd4,
        REQ_DEL_MID   = 4'd5,
        REQ_UPD_FRONT = 4'd6,
        REQ_UPD_MID   = 4'd7,
        REQ_UPD_BACK  = 4'd8,
        REQ_CLEAR     = 4'd9,
        REQ_READ      = 4'd10
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_RANGE  = 3'd2,
        ST_NOTMID = 3'd3,
        ST_FULL   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2,
        OP_WRITE = 2'd3
    } op_t;

    typedef struct packed {
        logic capture;
        logic exec;
    } cmd_t;

endpackage

### rtl/plsu_ctrl.sv
module plsu_ctrl
    import plsu_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready    = (state_reg == S_IDLE);
    assign m_tvalid    = (state_reg == S_OUT);
    assign cmd.capture = s_tready && s_tvalid;
    assign cmd.exec    = (state_reg == S_EXEC);

`ifndef ASSERT_OFF
    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready))
        else $error("request taken while a result is pending");

    a_exec_then_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_tvalid)
        else $error("result not offered after execution");

    a_capture_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> cmd.exec)
        else $error("accepted request not executed");
`endif

endmodule

### rtl/plsu_dp.sv
module plsu_dp
    import plsu_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    input  logic [IN_W-1:0]   s_tdata,
    input  logic [REQ_W-1:0]  s_tuser,
    output logic [OUT_W-1:0]  m_tdata
);

    req_t              req_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    status_t           status_reg, status_next;
    logic [VAL_W-1:0]  rd_reg, rd_next;
    logic [VAL_W-1:0]  entries_reg [DEPTH];
    logic [VAL_W-1:0]  from_lo [DEPTH];
    logic [VAL_W-1:0]  from_hi [DEPTH];

    op_t               op;
    logic [CNT_W-1:0]  at;
    logic [POS_W-1:0]  pos_m1;
    logic [POS_W-1:0]  count_ext;
    logic [CNT_W-1:0]  count_m1;
    logic              empty;
    logic              full;
    logic              in_range;
    status_t           mid_status;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= req_t'(s_tuser);
            pos_reg <= s_tdata[POS_W-1:0];
            val_reg <= s_tdata[IN_W-1:POS_W];
        end
    end

    assign pos_m1    = pos_reg - POS_W'(1);
    assign count_ext = POS_W'(count_reg);
    assign count_m1  = count_reg - CNT_W'(1);
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign in_range  = (pos_reg != '0) && (pos_reg <= count_ext);

    always_comb begin
        if (empty) begin
            mid_status = ST_EMPTY;
        end else if (!in_range) begin
            mid_status = ST_RANGE;
        end else if (pos_reg == POS_W'(1)) begin
            mid_status = ST_NOTMID;
        end else begin
            mid_status = ST_OK;
        end
    end

    // decode and status
    always_comb begin
        op          = OP_NONE;
        at          = '0;
        status_next = ST_OK;
        rd_next     = '0;
        count_next  = count_reg;
        case (req_reg)
            REQ_INS_FRONT, REQ_INS_BACK: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    op = OP_OPEN;
                    at = (req_reg == REQ_INS_FRONT) ? '0 : count_reg;
                end
            end
            REQ_INS_MID: begin
                status_next = mid_status;
                if (mid_status == ST_OK && full) begin
                    status_next = ST_FULL;
                end else if (mid_status == ST_OK) begin
                    op = OP_OPEN;
                    at = pos_m1[CNT_W-1:0];
                end
            end
            REQ_DEL_FRONT, REQ_DEL_BACK: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    op = OP_CLOSE;
                    at = (req_reg == REQ_DEL_FRONT) ? '0 : count_m1;
                end
            end
            REQ_DEL_MID: begin
                status_next = mid_status;
                if (mid_status == ST_OK) begin
                    op = OP_CLOSE;
                    at = pos_m1[CNT_W-1:0];
                end
            end
            REQ_UPD_FRONT, REQ_UPD_BACK: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    op = OP_WRITE;
                    at = (req_reg == REQ_UPD_FRONT) ? '0 : count_m1;
                end
            end
            REQ_UPD_MID: begin
                status_next = mid_status;
                if (mid_status == ST_OK) begin
                    op = OP_WRITE;
                    at = pos_m1[CNT_W-1:0];
                end
            end
            REQ_CLEAR: begin
                count_next = '0;
            end
            REQ_READ: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else if (!in_range) begin
                    status_next = ST_RANGE;
                end else begin
                    rd_next = entries_reg[pos_m1[IDX_W-1:0]];
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
        if (op == OP_OPEN) begin
            count_next = count_reg + CNT_W'(1);
        end else if (op == OP_CLOSE) begin
            count_next = count_m1;
        end
    end

    // neighbor taps of the shift chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_tap
        if (g > 0) begin : g_lo
            assign from_lo[g] = entries_reg[g-1];
        end else begin : g_lo0
            assign from_lo[g] = '0;
        end
        if (g < DEPTH - 1) begin : g_hi
            assign from_hi[g] = entries_reg[g+1];
        end else begin : g_hi0
            assign from_hi[g] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            for (int i = 0; i < DEPTH; i++) begin
                case (op)
                    OP_OPEN: begin
                        if (CNT_W'(i) == at) begin
                            entries_reg[i] <= val_reg;
                        end else if (CNT_W'(i) > at && CNT_W'(i) <= count_reg) begin
                            entries_reg[i] <= from_lo[i];
                        end
                    end
                    OP_CLOSE: begin
                        if (CNT_W'(i) >= at && (CNT_W'(i) + CNT_W'(1)) < count_reg) begin
                            entries_reg[i] <= from_hi[i];
                        end
                    end
                    OP_WRITE: begin
                        if (CNT_W'(i) == at) begin
                            entries_reg[i] <= val_reg;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg <= status_next;
            rd_reg     <= rd_next;
        end
    end

    assign m_tdata = {rd_reg, count_reg, status_reg};

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.exec |=> $stable(count_reg))
        else $error("entry count changed outside execution");

    a_full_no_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && full) |-> (op != OP_OPEN))
        else $error("insert into a full list");
`endif

endmodule

### rtl/positional_list_store_unit.sv
// positional list store: ordered list of up to 16 signed 32-bit entries
// input channel s_*: one request per handshake, s_tuser carries the
// request type, s_tdata carries position and value
// result channel m_*: exactly one result per request with status, the
// entry count after the request and the read value (zero unless an ok read)
// the taken request passes through the execute state and the result is
// then offered; a new request is taken only after that result is taken;
// the controller steps through accept, execute and result, and the
// entries shift in the cell chain in the execute cycle
// while a result waits on m_tready, s_tready stays low and the list holds
// reset (aresetn low, synchronous) empties the list and drops any pending
// request or result; entry contents are not cleared
module positional_list_store_unit
    import plsu_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // position[7:0], value[39:8]
    input  logic [REQ_W-1:0]  s_tuser,   // req_type[3:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata    // status[2:0], entry_count[7:3], read_value[39:8]
);

    cmd_t cmd;

    plsu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    plsu_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata)
    );

endmodule

### tb/list_store_checker.sv
`timescale 1ns / 1ps

module list_store_checker
    import plsu_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,
    input  logic [REQ_W-1:0]  s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata,
    output int                error_count,
    output int                results_owed
);

    typedef struct packed {
        status_t              status;
        logic [CNT_W-1:0]     entry_count;
        logic [VAL_W-1:0]     read_value;
    } list_result_t;

    list_result_t     expected_results[$];
    logic [VAL_W-1:0] slot [DEPTH];
    logic [CNT_W-1:0] live_count;
    int               mismatches;
    int               result_no;

    function automatic status_t mid_status(input logic [POS_W-1:0] pos);
        if (live_count == 0) return ST_EMPTY;
        if (pos == 0 || pos > live_count) return ST_RANGE;
        if (pos == 1) return ST_NOTMID;
        return ST_OK;
    endfunction

    function automatic void open_slot(input int at);
        int i;
        for (i = int'(live_count); i > at; i--)
            slot[i] = slot[i-1];
        live_count++;
    endfunction

    function automatic void close_slot(input int at);
        int i;
        for (i = at; i + 1 < int'(live_count); i++)
            slot[i] = slot[i+1];
        live_count--;
    endfunction

    function automatic list_result_t predict_list_req(input logic [REQ_W-1:0] req,
                                                      input logic [POS_W-1:0] pos,
                                                      input logic [VAL_W-1:0] val);
        list_result_t     res;
        status_t          st;
        logic [VAL_W-1:0] rd;
        int               at;
        st = ST_OK;
        rd = '0;
        case (req)
            REQ_INS_FRONT, REQ_INS_BACK: begin
                if (live_count >= DEPTH) begin
                    st = ST_FULL;
                end else begin
                    at = (req == REQ_INS_FRONT) ? 0 : int'(live_count);
                    open_slot(at);
                    slot[at] = val;
                end
            end
            REQ_INS_MID: begin
                st = mid_status(pos);
                if (st == ST_OK && live_count >= DEPTH) st = ST_FULL;
                if (st == ST_OK) begin
                    open_slot(int'(pos) - 1);
                    slot[int'(pos) - 1] = val;
                end
            end
            REQ_DEL_FRONT, REQ_DEL_BACK: begin
                if (live_count == 0) st = ST_EMPTY;
                else close_slot((req == REQ_DEL_FRONT) ? 0 : int'(live_count) - 1);
            end
            REQ_DEL_MID: begin
                st = mid_status(pos);
                if (st == ST_OK) close_slot(int'(pos) - 1);
            end
            REQ_UPD_FRONT, REQ_UPD_BACK: begin
                if (live_count == 0) st = ST_EMPTY;
                else slot[(req == REQ_UPD_FRONT) ? 0 : int'(live_count) - 1] = val;
            end
            REQ_UPD_MID: begin
                st = mid_status(pos);
                if (st == ST_OK) slot[int'(pos) - 1] = val;
            end
            REQ_CLEAR: begin
                live_count = '0;
            end
            REQ_READ: begin
                if (live_count == 0) st = ST_EMPTY;
                else if (pos == 0 || pos > live_count) st = ST_RANGE;
                else rd = slot[int'(pos) - 1];
            end
            default: begin
            end
        endcase
        res.status      = st;
        res.entry_count = live_count;
        res.read_value  = rd;
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        list_result_t     want;
        logic [STAT_W-1:0] got_status;
        logic [CNT_W-1:0]  got_count;
        logic [VAL_W-1:0]  got_read;
        if (!aresetn) begin
            live_count = '0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got_status = m_tdata[STAT_W-1:0];
                got_count  = m_tdata[STAT_W+CNT_W-1:STAT_W];
                got_read   = m_tdata[OUT_W-1:STAT_W+CNT_W];
                if (expected_results.size() == 0) begin
                    $error("result %0d with no request waiting: %h", result_no, m_tdata);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got_status !== want.status) begin
                        $error("result %0d status: expected %0d, got %0d",
                               result_no, want.status, got_status);
                        mismatches++;
                    end
                    if (got_count !== want.entry_count) begin
                        $error("result %0d entry_count: expected %0d, got %0d",
                               result_no, want.entry_count, got_count);
                        mismatches++;
                    end
                    if (got_read !== want.read_value) begin
                        $error("result %0d read_value: expected %0d, got %0d",
                               result_no, $signed(want.read_value), $signed(got_read));
                        mismatches++;
                    end
                end
                result_no++;
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_list_req(s_tuser, s_tdata[POS_W-1:0],
                                                            s_tdata[IN_W-1:POS_W]));
        end
        results_owed <= expected_results.size();
        error_count  <= mismatches + expected_results.size();
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import plsu_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED_TOP = '1;
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;
    localparam int REQ_ITEMS  = 1850;

    logic             aclk;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic [REQ_W-1:0] s_tuser  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    int               error_count;
    int               results_owed;
    bit               gaps_on  = 1'b1;

    positional_list_store_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    list_store_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .error_count  (error_count),
        .results_owed (results_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

    initial begin : ready_gen
        int hold;
        int r;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    m_tready <= 1'b1;
                    hold = $urandom_range(0, 20);
                end else if (r < 90) begin
                    m_tready <= 1'b0;
                    hold = $urandom_range(0, 3);
                end else begin
                    m_tready <= 1'b0;
                    hold = $urandom_range(4, 30);
                end
            end
        end
    end

    function automatic logic [POS_W-1:0] pick_pos();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return POS_W'($urandom_range(0, DEPTH + 1));
        return POS_W'($urandom);
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 32'h8000_0000;
        if (r < 6) return 32'h7FFF_FFFF;
        if (r < 8) return '0;
        if (r < 10) return '1;
        return $urandom;
    endfunction

    function automatic req_t pick_req(input int mode);
        int r;
        int ins_pct;
        int del_pct;
        ins_pct = (mode == MODE_FILL) ? 60 : (mode == MODE_DRAIN) ? 15 : 33;
        del_pct = (mode == MODE_FILL) ? 12 : (mode == MODE_DRAIN) ? 55 : 30;
        r = $urandom_range(0, 99);
        if (r < 2)
            return req_t'($urandom_range(int'(REQ_READ) + 1, int'(REQ_UNUSED_TOP)));
        if (r < 4) return REQ_CLEAR;
        r = r - 4;
        if (r < ins_pct) begin
            case ($urandom_range(0, 2))
                0:       return REQ_INS_FRONT;
                1:       return REQ_INS_BACK;
                default: return REQ_INS_MID;
            endcase
        end
        r = r - ins_pct;
        if (r < del_pct) begin
            case ($urandom_range(0, 2))
                0:       return REQ_DEL_FRONT;
                1:       return REQ_DEL_BACK;
                default: return REQ_DEL_MID;
            endcase
        end
        if ($urandom_range(0, 99) < 55) return REQ_READ;
        case ($urandom_range(0, 2))
            0:       return REQ_UPD_FRONT;
            1:       return REQ_UPD_BACK;
            default: return REQ_UPD_MID;
        endcase
    endfunction

    task automatic issue_req(input logic [REQ_W-1:0] rt, input logic [POS_W-1:0] pos,
                             input logic [VAL_W-1:0] val);
        int r;
        int n;
        s_tvalid <= 1'b1;
        s_tuser  <= rt;
        s_tdata  <= {val, pos};
        do @(posedge aclk); while (!s_tready);
        // sender gaps: mostly none or short, a few long
        if (gaps_on) begin
            r = $urandom_range(0, 99);
            n = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(4, 30);
            if (n > 0) begin
                s_tvalid <= 1'b0;
                repeat (n) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
    endtask

    initial begin : stim
        int   counted;
        int   mode;
        int   phase_len;
        int   phase_no;
        int   i;
        req_t rt;
        counted  = 0;
        phase_no = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list
        issue_req(REQ_READ,      8'd1, '0);
        issue_req(REQ_DEL_FRONT, 8'd0, '0);
        issue_req(REQ_DEL_BACK,  8'd0, '0);
        issue_req(REQ_DEL_MID,   8'd2, '0);
        issue_req(REQ_UPD_FRONT, 8'd0, 32'h1234_5678);
        issue_req(REQ_UPD_MID,   8'd2, 32'h1234_5678);
        issue_req(REQ_UPD_BACK,  8'd0, 32'h1234_5678);
        issue_req(REQ_INS_MID,   8'd2, 32'h1234_5678);
        issue_req(REQ_CLEAR,     8'd0, '0);
        // value extremes at both ends
        issue_req(REQ_INS_FRONT, 8'd0, 32'h8000_0000);
        issue_req(REQ_INS_BACK,  8'd0, 32'h7FFF_FFFF);
        issue_req(REQ_INS_BACK,  8'hFF, '0);
        issue_req(REQ_INS_FRONT, 8'd0, '1);
        // read range
        issue_req(REQ_READ,      8'd0,  '0);
        issue_req(REQ_READ,      8'hFF, '0);
        issue_req(REQ_READ,      8'd4,  '0);
        // middle range
        issue_req(REQ_INS_MID,   8'd1, 32'h0F0F_0F0F);
        issue_req(REQ_INS_MID,   8'd0, 32'h0F0F_0F0F);
        issue_req(REQ_INS_MID,   8'd5, 32'h0F0F_0F0F);
        issue_req(REQ_INS_MID,   8'd4, 32'h5A5A_5A5A);
        issue_req(REQ_UPD_MID,   8'd2, 32'hA5A5_A5A5);
        // delete at the last position shifts no entries
        issue_req(REQ_DEL_MID,   8'd5, '0);
        issue_req(REQ_UPD_BACK,  8'd0, 32'hCAFE_F00D);
        issue_req(REQ_READ,      8'd4, '0);
        issue_req(REQ_UNUSED_TOP, 8'hAA, 32'h5555_AAAA);

        while (counted < REQ_ITEMS) begin
            mode      = $urandom_range(MODE_FILL, MODE_MIXED);
            phase_len = $urandom_range(60, 160);
            gaps_on   = ($urandom_range(0, 4) != 0);
            for (i = 0; i < phase_len && counted < REQ_ITEMS; i++) begin
                rt = pick_req(mode);
                issue_req(rt, pick_pos(), pick_value());
                if (rt <= REQ_READ) counted++;
            end
            if (phase_no == 1 || $urandom_range(0, 2) == 0) wait_drained();
            phase_no++;
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
